FILE: src/hsvc_pkg.sv
package hsvc_pkg;

  // Channel and fixed-point widths.
  localparam int unsigned ChanW  = 8;
  localparam int unsigned LimW   = 16;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned FracW  = 12;
  localparam int unsigned SdivW  = 20;
  localparam int unsigned HdivW  = 17;
  localparam int unsigned HdiffW = 12;
  localparam int unsigned SprodW = 28;
  localparam int unsigned HprodW = 30;

  // Scaled numerators of the two reciprocal tables.
  localparam int unsigned SatNum = 255 * 4096;
  localparam int unsigned HueNum = 180 * 4096;
  localparam int unsigned RoundHalf = 2048;

  localparam logic [ChanW-1:0] FullScale = 8'd255;
  localparam logic [ChanW:0]   HueSpan   = 9'd180;

  // Configuration register indices.
  localparam logic [IdxW-1:0] RegHueLimits   = 3'd0;
  localparam logic [IdxW-1:0] RegHueWrap     = 3'd1;
  localparam logic [IdxW-1:0] RegSatLimits   = 3'd2;
  localparam logic [IdxW-1:0] RegValLimits   = 3'd3;
  localparam logic [IdxW-1:0] RegBlueLimits  = 3'd4;
  localparam logic [IdxW-1:0] RegGreenLimits = 3'd5;
  localparam logic [IdxW-1:0] RegRedLimits   = 3'd6;

  // Reset values of the limit registers.
  localparam logic [LimW-1:0] HueLimitsRst = 16'hB400;
  localparam logic [LimW-1:0] ChanLimitsRst = 16'hFF00;

  // Pixel fields that travel alongside the conversion.
  typedef struct packed {
    logic             line_present;
    logic [ChanW-1:0] line_value;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pix_t;

  // Converted colour.
  typedef struct packed {
    logic [ChanW-1:0] hue;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] val;
  } hsv_t;

endpackage

FILE: src/hsvc_convert.sv
// Four-stage BGR to HSV conversion with per-stage flow control.
module hsvc_convert (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  hsvc_pkg::pix_t pix_i,
  output logic          valid_o,
  input  logic          ready_i,
  output hsvc_pkg::pix_t pix_o,
  output hsvc_pkg::hsv_t hsv_o
);

  // Reciprocal tables; entry zero is zero so that the degenerate cases fall out.
  logic [hsvc_pkg::SdivW-1:0] sdiv_rom [256];
  logic [hsvc_pkg::HdivW-1:0] hdiv_rom [256];

  for (genvar gi = 0; gi < 256; gi++) begin : g_rom
    localparam int unsigned Den  = (gi == 0) ? 1 : gi;
    localparam int unsigned SQuo = (2 * hsvc_pkg::SatNum + Den) / (2 * Den);
    localparam int unsigned HQuo = (2 * hsvc_pkg::HueNum + 6 * Den) / (12 * Den);
    assign sdiv_rom[gi] = (gi == 0) ? '0 : hsvc_pkg::SdivW'(SQuo);
    assign hdiv_rom[gi] = (gi == 0) ? '0 : hsvc_pkg::HdivW'(HQuo);
  end

  // Stage valids and enables: a stage loads when it is empty or its content moves on.
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4     = !v4_q || ready_i;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Stage 1: maximum, minimum, spread and the hue numerator.
  logic [hsvc_pkg::ChanW-1:0]         max_d, min_d, dif_d;
  logic signed [hsvc_pkg::HdiffW-1:0] h0_d;
  logic signed [hsvc_pkg::HdiffW-1:0] b_s, g_s, r_s, d_s;

  always_comb begin
    max_d = pix_i.blue;
    min_d = pix_i.blue;
    if (pix_i.green > max_d) max_d = pix_i.green;
    if (pix_i.red > max_d) max_d = pix_i.red;
    if (pix_i.green < min_d) min_d = pix_i.green;
    if (pix_i.red < min_d) min_d = pix_i.red;
    dif_d = max_d - min_d;
    b_s = $signed({4'b0, pix_i.blue});
    g_s = $signed({4'b0, pix_i.green});
    r_s = $signed({4'b0, pix_i.red});
    d_s = $signed({4'b0, dif_d});
    if (max_d == pix_i.red) begin
      h0_d = g_s - b_s;
    end else if (max_d == pix_i.green) begin
      h0_d = b_s - r_s + (d_s <<< 1);
    end else begin
      h0_d = r_s - g_s + (d_s <<< 2);
    end
  end

  hsvc_pkg::pix_t                     pix1_q;
  logic [hsvc_pkg::ChanW-1:0]         max1_q, dif1_q;
  logic signed [hsvc_pkg::HdiffW-1:0] h01_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      pix1_q <= pix_i;
      max1_q <= max_d;
      dif1_q <= dif_d;
      h01_q  <= h0_d;
    end
  end

  // Stage 2: reciprocal lookups.
  hsvc_pkg::pix_t                     pix2_q;
  logic [hsvc_pkg::ChanW-1:0]         max2_q, dif2_q;
  logic signed [hsvc_pkg::HdiffW-1:0] h02_q;
  logic [hsvc_pkg::SdivW-1:0]         sdiv2_q;
  logic [hsvc_pkg::HdivW-1:0]         hdiv2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      pix2_q  <= pix1_q;
      max2_q  <= max1_q;
      dif2_q  <= dif1_q;
      h02_q   <= h01_q;
      sdiv2_q <= sdiv_rom[max1_q];
      hdiv2_q <= hdiv_rom[dif1_q];
    end
  end

  // Stage 3: the two products.
  logic [hsvc_pkg::SprodW-1:0]        sprod_d;
  logic signed [hsvc_pkg::HprodW-1:0] hprod_d;

  assign sprod_d = hsvc_pkg::SprodW'(dif2_q) * hsvc_pkg::SprodW'(sdiv2_q);
  assign hprod_d = hsvc_pkg::HprodW'(h02_q) * hsvc_pkg::HprodW'($signed({1'b0, hdiv2_q}));

  hsvc_pkg::pix_t                     pix3_q;
  logic [hsvc_pkg::ChanW-1:0]         max3_q;
  logic [hsvc_pkg::SprodW-1:0]        sprod3_q;
  logic signed [hsvc_pkg::HprodW-1:0] hprod3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      pix3_q   <= pix2_q;
      max3_q   <= max2_q;
      sprod3_q <= sprod_d;
      hprod3_q <= hprod_d;
    end
  end

  // Stage 4: rounding; the arithmetic shift floors negative hue, then it wraps by 180.
  logic [hsvc_pkg::SprodW-1:0]        ssum;
  logic signed [hsvc_pkg::HprodW-1:0] hsum, hshift;
  logic signed [hsvc_pkg::ChanW:0]    hraw;
  logic [hsvc_pkg::ChanW:0]           hwrap;
  hsvc_pkg::hsv_t                     hsv_d;

  always_comb begin
    ssum   = sprod3_q + hsvc_pkg::SprodW'(hsvc_pkg::RoundHalf);
    hsum   = hprod3_q + hsvc_pkg::HprodW'(hsvc_pkg::RoundHalf);
    hshift = hsum >>> hsvc_pkg::FracW;
    hraw   = hshift[hsvc_pkg::ChanW:0];
    hwrap  = hraw[hsvc_pkg::ChanW] ? (hraw + hsvc_pkg::HueSpan) : hraw;
    hsv_d.hue = hwrap[hsvc_pkg::ChanW-1:0];
    hsv_d.sat = ssum[hsvc_pkg::FracW +: hsvc_pkg::ChanW];
    hsv_d.val = max3_q;
  end

  hsvc_pkg::pix_t pix4_q;
  hsvc_pkg::hsv_t hsv4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      pix4_q <= pix3_q;
      hsv4_q <= hsv_d;
    end
  end

  assign pix_o = pix4_q;
  assign hsv_o = hsv4_q;

endmodule

FILE: src/hsv_rgb_range_pixel_classifier.sv
// Colour-window pixel classifier on a BGR stream.
// Pipeline: four conversion stages plus the compare stage, which is also the output
// register. Throughput: one pixel per cycle unless the output stalls; every stage
// moves on independently, so bubbles close up.
// Reset: asynchronous, active low; clears all stage valids and loads the limit registers
// with their defaults (hue 0 to 180 unwrapped, every other window 0 to 255).
module hsv_rgb_range_pixel_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Pixel input.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // blue, green, red, line_value
  input  logic                          s_axis_tuser,  // line_present
  // Mask output.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // mask_value
  // Register writes.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hsvc_pkg::IdxW-1:0]     cfg_index_i,
  input  logic [hsvc_pkg::LimW-1:0]     cfg_data_i
);

  // Limit registers.
  logic [hsvc_pkg::LimW-1:0] hue_lim_q, sat_lim_q, val_lim_q;
  logic [hsvc_pkg::LimW-1:0] blue_lim_q, green_lim_q, red_lim_q;
  logic                      hue_wrap_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_lim_q   <= hsvc_pkg::HueLimitsRst;
      hue_wrap_q  <= 1'b0;
      sat_lim_q   <= hsvc_pkg::ChanLimitsRst;
      val_lim_q   <= hsvc_pkg::ChanLimitsRst;
      blue_lim_q  <= hsvc_pkg::ChanLimitsRst;
      green_lim_q <= hsvc_pkg::ChanLimitsRst;
      red_lim_q   <= hsvc_pkg::ChanLimitsRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hsvc_pkg::RegHueLimits:   hue_lim_q   <= cfg_data_i;
        hsvc_pkg::RegHueWrap:     hue_wrap_q  <= cfg_data_i[0];
        hsvc_pkg::RegSatLimits:   sat_lim_q   <= cfg_data_i;
        hsvc_pkg::RegValLimits:   val_lim_q   <= cfg_data_i;
        hsvc_pkg::RegBlueLimits:  blue_lim_q  <= cfg_data_i;
        hsvc_pkg::RegGreenLimits: green_lim_q <= cfg_data_i;
        hsvc_pkg::RegRedLimits:   red_lim_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack the input transfer.
  hsvc_pkg::pix_t pix_in;

  assign pix_in.blue         = s_axis_tdata[7:0];
  assign pix_in.green        = s_axis_tdata[15:8];
  assign pix_in.red          = s_axis_tdata[23:16];
  assign pix_in.line_value   = s_axis_tdata[31:24];
  assign pix_in.line_present = s_axis_tuser;

  // Conversion pipeline.
  logic           conv_valid, conv_ready;
  hsvc_pkg::pix_t conv_pix;
  hsvc_pkg::hsv_t conv_hsv;

  hsvc_convert u_convert (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .pix_i   (pix_in),
    .valid_o (conv_valid),
    .ready_i (conv_ready),
    .pix_o   (conv_pix),
    .hsv_o   (conv_hsv)
  );

  // Window tests: low < x <= high, with the hue band optionally inverted.
  function automatic logic in_band(input logic [7:0] x, input logic [15:0] lim);
    in_band = (x > lim[7:0]) && (x <= lim[15:8]);
  endfunction

  logic       hue_ok, all_ok;
  logic [7:0] mask_d;

  always_comb begin
    if (hue_wrap_q) begin
      hue_ok = (conv_hsv.hue > hue_lim_q[15:8]) || (conv_hsv.hue <= hue_lim_q[7:0]);
    end else begin
      hue_ok = in_band(conv_hsv.hue, hue_lim_q);
    end
    all_ok = hue_ok
          && in_band(conv_hsv.sat, sat_lim_q)
          && in_band(conv_hsv.val, val_lim_q)
          && in_band(conv_pix.blue, blue_lim_q)
          && in_band(conv_pix.green, green_lim_q)
          && in_band(conv_pix.red, red_lim_q);
    mask_d = (all_ok ? hsvc_pkg::FullScale : 8'd0)
           | (conv_pix.line_present ? conv_pix.line_value : 8'd0);
  end

  // Output register.
  logic       out_valid_q;
  logic [7:0] mask_q;

  assign conv_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (conv_ready) begin
      out_valid_q <= conv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (conv_ready) begin
      mask_q <= mask_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = mask_q;

`ifndef ASSERT_OFF
  // The converted hue always lies below the hue span, HueSpan.
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_valid |-> ({1'b0, conv_hsv.hue} < hsvc_pkg::HueSpan))
    else $error("hue out of range");

  // A black pixel cannot carry saturation.
  a_sat_needs_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (conv_valid && (conv_hsv.sat != 8'd0)) |-> (conv_hsv.val != 8'd0))
    else $error("saturation without value");

  // The input only stalls when a finished result is held at the output.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with an empty output");
`endif

endmodule

FILE: tb/tb_hsv_rgb_range_pixel_classifier.sv
`timescale 1ns / 1ps

module tb_hsv_rgb_range_pixel_classifier;
  import hsvc_pkg::*;

  localparam int SatScaled = 255 * 4096;
  localparam int HueScaled = 180 * 4096;
  localparam int NumRegs   = 7;
  localparam logic [IdxW-1:0] RegUnused = 3'd7;

  logic clk = 1'b0;
  logic rst_ni;

  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // blue, green, red, line_value
  logic        s_axis_tuser;   // line_present
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // mask_value
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [IdxW-1:0] cfg_index_i;
  logic [LimW-1:0] cfg_data_i;

  // Shadow copy of the window registers; the wrap flag sits in bit 0 of its slot.
  logic [LimW-1:0] win_q [0:NumRegs-1];
  logic [7:0]      mask_due [$];
  logic [7:0]      mask_want;
  int              mask_errors = 0;
  bit              src_stalls;
  bit              sink_stalls;
  int              sink_hold = 0;
  int              cen_b, cen_g, cen_r;

  hsv_rgb_range_pixel_classifier dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk = ~clk;

  // Window test: strictly above the low byte, at or below the high byte.
  function automatic bit in_window(input int x, input logic [LimW-1:0] lim);
    return (x > int'(lim[7:0])) && (x <= int'(lim[15:8]));
  endfunction

  // Mask byte expected for one pixel under the current windows.
  function automatic logic [7:0] predict_mask(input logic [7:0] b, input logic [7:0] g,
                                              input logic [7:0] r, input logic [7:0] lv,
                                              input logic lp);
    int bi, gi, ri, v, mn, d, s, h, h0, hdiv, t;
    bit hue_ok, pass;
    logic [7:0] m;
    bi = b;
    gi = g;
    ri = r;
    v  = bi;
    if (gi > v) v = gi;
    if (ri > v) v = ri;
    mn = bi;
    if (gi < mn) mn = gi;
    if (ri < mn) mn = ri;
    d = v - mn;

    s = 0;
    if (v != 0) s = (d * ((2 * SatScaled + v) / (2 * v)) + 2048) >>> 12;

    // Half-degree hue with floor division, folded into 0..179.
    h = 0;
    if (d != 0) begin
      if (v == ri) h0 = gi - bi;
      else if (v == gi) h0 = bi - ri + 2 * d;
      else h0 = ri - gi + 4 * d;
      hdiv = (2 * HueScaled + 6 * d) / (12 * d);
      t = h0 * hdiv + 2048;
      if (t >= 0) h = t / 4096;
      else h = -((-t + 4095) / 4096);
      if (h < 0) h += 180;
    end

    if (win_q[RegHueWrap][0]) begin
      hue_ok = (h > int'(win_q[RegHueLimits][15:8])) || (h <= int'(win_q[RegHueLimits][7:0]));
    end else begin
      hue_ok = in_window(h, win_q[RegHueLimits]);
    end

    pass = hue_ok && in_window(s, win_q[RegSatLimits]) && in_window(v, win_q[RegValLimits])
           && in_window(bi, win_q[RegBlueLimits]) && in_window(gi, win_q[RegGreenLimits])
           && in_window(ri, win_q[RegRedLimits]);
    m = pass ? FullScale : 8'd0;
    if (lp) m = m | lv;
    return m;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return $urandom_range(1, 3);
    if (p < 90) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int near_value(input int c);
    int x;
    x = c + int'($urandom_range(0, 60)) - 30;
    if (x < 0) x = 0;
    if (x > 255) x = 255;
    return x;
  endfunction

  // Drives one pixel transfer and records the mask it should produce.
  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                            input logic [7:0] lv, input logic lp);
    int gap;
    gap = 0;
    if (src_stalls && $urandom_range(0, 99) < 45) gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {lv, r, g, b};
    s_axis_tuser  <= lp;
    do @(posedge clk); while (!s_axis_tready);
    mask_due.push_back(predict_mask(b, g, r, lv, lp));
  endtask

  // Lowers valid once a run of pixels is over, then waits for the pipe to empty.
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (mask_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [LimW-1:0] data);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    if (idx == RegHueWrap) win_q[idx] = {15'd0, data[0]};
    else if (idx != RegUnused) win_q[idx] = data;
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_pixel();
    int p;
    logic [7:0] b, g, r;
    p = $urandom_range(0, 99);
    if (p < 35) begin
      b = $urandom_range(0, 255);
      g = $urandom_range(0, 255);
      r = $urandom_range(0, 255);
    end else if (p < 70) begin
      b = near_value(cen_b);
      g = near_value(cen_g);
      r = near_value(cen_r);
    end else if (p < 85) begin
      b = $urandom_range(0, 255);
      g = b;
      r = b;
    end else begin
      b = ($urandom_range(0, 2) == 0) ? 8'd0 : (($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom));
      g = ($urandom_range(0, 2) == 0) ? 8'd0 : (($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom));
      r = ($urandom_range(0, 1) == 0) ? b : 8'($urandom);
    end
    send_pixel(b, g, r, 8'($urandom), 1'($urandom));
  endtask

  // Reset windows: black, white, primaries and the line-mask merge.
  task automatic test_reset_windows();
    src_stalls  = 1'b0;
    sink_stalls = 1'b0;
    send_pixel(8'd0,   8'd0,   8'd0,   8'h00, 1'b0);
    send_pixel(8'd0,   8'd0,   8'd0,   8'hA5, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 8'hFF, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'h5A, 1'b1);
    send_pixel(8'd255, 8'd0,   8'd0,   8'h00, 1'b0);
    send_pixel(8'd0,   8'd255, 8'd0,   8'h00, 1'b0);
    send_pixel(8'd0,   8'd0,   8'd255, 8'h00, 1'b0);
    send_pixel(8'd1,   8'd2,   8'd3,   8'h81, 1'b1);
    send_pixel(8'd40,  8'd200, 8'd90,  8'hFF, 1'b0);
    send_pixel(8'd200, 8'd40,  8'd254, 8'h00, 1'b1);
    settle();
  endtask

  // Hue bound above the span, wrapped band, empty band, stray index, wide data.
  task automatic test_register_corners();
    write_reg(RegHueLimits, {8'd200, 8'd0});
    send_pixel(8'd10,  8'd250, 8'd250, 8'h00, 1'b0);
    send_pixel(8'd250, 8'd10,  8'd200, 8'h00, 1'b0);
    settle();
    write_reg(RegHueLimits, {8'd60, 8'd20});
    write_reg(RegHueWrap, 16'hFFFF);
    send_pixel(8'd0,   8'd0,   8'd255, 8'h00, 1'b0);
    send_pixel(8'd0,   8'd255, 8'd0,   8'h00, 1'b0);
    send_pixel(8'd0,   8'd255, 8'd255, 8'h00, 1'b0);
    send_pixel(8'd60,  8'd120, 8'd200, 8'h00, 1'b0);
    settle();
    write_reg(RegHueWrap, 16'hFFFE);
    write_reg(RegSatLimits, 16'h4040);
    send_pixel(8'd0,   8'd255, 8'd255, 8'h0F, 1'b1);
    send_pixel(8'd30,  8'd80,  8'd160, 8'h00, 1'b0);
    settle();
    write_reg(RegUnused, 16'h1234);
    write_reg(RegSatLimits, ChanLimitsRst);
    write_reg(RegValLimits, 16'hC880);
    write_reg(RegBlueLimits, 16'h8000);
    write_reg(RegGreenLimits, 16'hFF10);
    write_reg(RegRedLimits, 16'hFE00);
    send_pixel(8'd20,  8'd100, 8'd201, 8'h00, 1'b0);
    send_pixel(8'd128, 8'd17,  8'd150, 8'h00, 1'b0);
    send_pixel(8'd0,   8'd16,  8'd255, 8'h3C, 1'b1);
    settle();
  endtask

  // Random windows of several kinds, each followed by a run of random pixels.
  task automatic test_random_phases(input int phases, input int pixels);
    int kind, i, k, c;
    logic [LimW-1:0] corner [4];
    corner[0] = 16'h0000;
    corner[1] = 16'hFFFF;
    corner[2] = 16'hFF00;
    corner[3] = 16'h00FF;
    for (i = 0; i < phases; i++) begin
      kind = i % 4;
      cen_b = $urandom_range(0, 255);
      cen_g = $urandom_range(0, 255);
      cen_r = $urandom_range(0, 255);
      case (kind)
        0: begin
          write_reg(RegHueLimits, {8'($urandom_range(90, 200)), 8'($urandom_range(0, 60))});
          write_reg(RegHueWrap, 16'($urandom));
          for (k = int'(RegSatLimits); k <= int'(RegRedLimits); k++) begin
            write_reg(IdxW'(k), {8'($urandom_range(160, 255)), 8'($urandom_range(0, 80))});
          end
        end
        1: begin
          write_reg(RegHueWrap, 16'($urandom_range(0, 1)));
          for (k = 0; k < NumRegs; k++) begin
            if (k != int'(RegHueWrap)) write_reg(IdxW'(k), corner[$urandom_range(0, 3)]);
          end
        end
        2: begin
          for (k = 0; k <= int'(RegUnused); k++) write_reg(IdxW'(k), 16'($urandom));
        end
        default: begin
          // Hue window that admits everything, channel windows around the centre colour.
          write_reg(RegHueLimits, 16'h0000);
          write_reg(RegHueWrap, 16'd1);
          write_reg(RegSatLimits, ChanLimitsRst);
          write_reg(RegValLimits, ChanLimitsRst);
          c = cen_b;
          write_reg(RegBlueLimits, {8'((c + 24 > 255) ? 255 : c + 24), 8'((c < 24) ? 0 : c - 24)});
          c = cen_g;
          write_reg(RegGreenLimits, {8'((c + 24 > 255) ? 255 : c + 24), 8'((c < 24) ? 0 : c - 24)});
          c = cen_r;
          write_reg(RegRedLimits, {8'((c + 24 > 255) ? 255 : c + 24), 8'((c < 24) ? 0 : c - 24)});
        end
      endcase
      src_stalls  = (i % 3) != 1;
      sink_stalls = (i % 3) != 2;
      for (k = 0; k < pixels; k++) random_pixel();
      settle();
    end
  endtask

  // Output ready with random hold-offs of mostly short length.
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (sink_stalls && $urandom_range(0, 99) < 20) sink_hold = pick_gap();
    end
  end

  // Compare every mask transfer with the oldest outstanding prediction.
  always @(posedge clk) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (mask_due.size() == 0) begin
        $display("%0t: mask transfer with nothing outstanding, actual %02h",
                 $time, m_axis_tdata);
        mask_errors++;
      end else begin
        mask_want = mask_due.pop_front();
        if (m_axis_tdata !== mask_want) begin
          $display("%0t: mask_value mismatch, expected %02h, actual %02h",
                   $time, mask_want, m_axis_tdata);
          mask_errors++;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    src_stalls    = 1'b0;
    sink_stalls   = 1'b0;
    cen_b = 128;
    cen_g = 128;
    cen_r = 128;
    win_q[RegHueLimits]   = HueLimitsRst;
    win_q[RegHueWrap]     = '0;
    win_q[RegSatLimits]   = ChanLimitsRst;
    win_q[RegValLimits]   = ChanLimitsRst;
    win_q[RegBlueLimits]  = ChanLimitsRst;
    win_q[RegGreenLimits] = ChanLimitsRst;
    win_q[RegRedLimits]   = ChanLimitsRst;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk);

    test_reset_windows();
    test_register_corners();
    test_random_phases(6, 155);

    while (mask_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mask_errors == 0) begin
      $display("tb_hsv_rgb_range_pixel_classifier: done, clean");
    end else begin
      $display("tb_hsv_rgb_range_pixel_classifier: done, errors");
    end
    $finish;
  end

  // Watchdog for a stuck handshake.
  initial begin
    #10_000_000;
    $display("tb_hsv_rgb_range_pixel_classifier: done, errors");
    $finish;
  end

endmodule
